// File: hdl/dmfs_pkg.sv
package dmfs_pkg;

    localparam int MOTORS      = 8;
    localparam int QUEUE_DEPTH = 8;

    localparam int MIDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam int CNT_W  = 5;
    localparam int QIDX_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] THROTTLE_MAX      = 16'd2047;
    localparam logic [31:0] CMD_INTERVAL_US   = 32'd10000;
    localparam logic [31:0] CMD_REPEAT_US     = 32'd1000;
    localparam logic [3:0]  SPIN_REPEATS      = 4'd10;
    localparam logic [5:0]  CMD_SPIN_NORMAL   = 6'd20;
    localparam logic [5:0]  CMD_SPIN_REVERSED = 6'd21;

    localparam logic [1:0] CFG_MOTOR_COUNT     = 2'd0;
    localparam logic [1:0] CFG_CONFIGURED_MASK = 2'd1;
    localparam logic [1:0] CFG_UPDATE_INTERVAL = 2'd2;
    localparam logic [1:0] CFG_MOTORS_ENABLED  = 2'd3;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_TELEM = 2'd1,
        OP_PUSH  = 2'd2,
        OP_TICK  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_COMMAND,
        ST_WALK
    } t_state;

    typedef struct packed {
        t_op         operation;
        logic [3:0]  motor_index;
        logic [15:0] throttle;
        logic [5:0]  command_code;
        logic [31:0] now_us;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  out_motor;
        logic [15:0] frame;
        logic        last;
    } t_out_word;

    function automatic logic is_cfg(input logic [CNT_W-1:0] m, input logic [7:0] mask);
        logic r;
        r = (m < CNT_W'(8)) && mask[m[2:0]];
        return r;
    endfunction

endpackage

// File: hdl/dmfs_frame_gen.sv
module dmfs_frame_gen
    import dmfs_pkg::*;
(
    input  logic [10:0] i_value,
    input  logic        i_tlm,
    output logic [15:0] o_frame
);

    logic [11:0] w_packet;
    logic [3:0]  w_csum;

    assign w_packet = {i_value, i_tlm};
    assign w_csum   = w_packet[3:0] ^ w_packet[7:4] ^ w_packet[11:8];
    assign o_frame  = {w_packet, w_csum};

endmodule

// File: hdl/dshot_motor_frame_scheduler.sv
// channel | direction | handshake           | word
// in      | input     | i_in_valid/o_in_stall   | t_in_word
// out     | output    | o_out_valid/i_out_stall | t_out_word
// cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
// write, telemetry request and push are taken in idle and leave the block idle
// a tick passes the update and command states through the shared time subtractor, then,
// if frames are due, walks the motors below the motor count, moving past a configured
// motor only while the output register is free
// i_out_stall holds the walk on a configured motor; the input stalls until the tick ends
// reset is synchronous, active low; the command store keeps its contents
module dshot_motor_frame_scheduler
    import dmfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [3:0]  r_motor_count;
    logic [7:0]  r_cfg_mask;
    logic [15:0] r_interval;
    logic        r_enabled;

    logic [10:0] r_value [MOTORS];
    logic [10:0] n_value [MOTORS];
    logic        r_tlm   [MOTORS];
    logic        n_tlm   [MOTORS];
    logic [5:0]  r_cmd_store [QUEUE_DEPTH];

    logic [QIDX_W-1:0] r_q_head, n_q_head;
    logic [QCNT_W-1:0] r_q_count, n_q_count;
    logic [5:0]  r_act, n_act;
    logic [3:0]  r_rep, n_rep;
    logic        r_post, n_post;
    logic [31:0] r_last_cmd, n_last_cmd;
    logic [31:0] r_last_upd, n_last_upd;
    logic [31:0] r_now;
    logic [CNT_W-1:0] r_mi, n_mi;

    logic      r_out_valid, n_out_valid;
    t_out_word r_out, n_out;

    logic             w_accept;
    logic [31:0]      w_diff;
    logic             w_upd_ok;
    logic             w_gt_gap, w_lt_gap, w_ge_rep;
    logic             w_pop, w_override, w_send;
    logic [5:0]       w_head_cmd;
    logic             w_spin;
    logic [3:0]       w_rep_base;
    logic [CNT_W-1:0] w_active;
    logic [CNT_W-1:0] w_mc;
    logic [CNT_W-1:0] w_idx;
    logic             w_walk_done, w_walk_cfg, w_out_free, w_load, w_rest;
    logic [QCNT_W:0]  w_wr_sum;
    logic [QIDX_W-1:0] w_wr_addr;
    logic             w_push;
    logic [15:0]      w_frame;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign w_mc     = {1'b0, r_motor_count};
    assign w_active = (w_mc > CNT_W'(MOTORS)) ? CNT_W'(MOTORS) : w_mc;
    assign w_idx    = {1'b0, i_in_word.motor_index};

    // shared time subtractor
    assign w_diff   = r_now - ((r_state == ST_UPDATE) ? r_last_upd : r_last_cmd);
    assign w_upd_ok = (r_interval != 16'd0) && (w_diff > {16'd0, r_interval});
    assign w_gt_gap = w_diff > CMD_INTERVAL_US;
    assign w_lt_gap = w_diff < CMD_INTERVAL_US;
    assign w_ge_rep = w_diff >= CMD_REPEAT_US;

    assign w_head_cmd = r_cmd_store[r_q_head];
    assign w_pop      = (r_rep == 4'd0) && (r_q_count != '0) && w_gt_gap;
    assign w_override = w_pop || (r_rep != 4'd0);
    assign w_spin     = (w_head_cmd == CMD_SPIN_NORMAL) || (w_head_cmd == CMD_SPIN_REVERSED);
    assign w_rep_base = w_pop ? (w_spin ? SPIN_REPEATS : 4'd1) : r_rep;
    assign w_send     = w_override ? w_ge_rep : !(r_post && w_lt_gap);

    assign w_wr_sum  = {{(QCNT_W + 1 - QIDX_W){1'b0}}, r_q_head} + {1'b0, r_q_count};
    assign w_wr_addr = (w_wr_sum >= (QCNT_W + 1)'(QUEUE_DEPTH))
                     ? QIDX_W'(w_wr_sum - (QCNT_W + 1)'(QUEUE_DEPTH))
                     : QIDX_W'(w_wr_sum);
    assign w_push    = w_accept && (i_in_word.operation == OP_PUSH)
                     && (r_q_count < QCNT_W'(QUEUE_DEPTH));

    assign w_walk_done = (r_mi >= w_active);
    assign w_walk_cfg  = is_cfg(r_mi, r_cfg_mask);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_load      = (r_state == ST_WALK) && !w_walk_done && w_walk_cfg && w_out_free;

    // any configured motor left after the current one
    always_comb begin
        w_rest = 1'b0;
        for (int m = 0; m < MOTORS; m++) begin
            if ((CNT_W'(m) > r_mi) && (CNT_W'(m) < w_active) && is_cfg(CNT_W'(m), r_cfg_mask)) begin
                w_rest = 1'b1;
            end
        end
    end

    dmfs_frame_gen u_frame_gen (
        .i_value (r_value[r_mi[MIDX_W-1:0]]),
        .i_tlm   (r_tlm[r_mi[MIDX_W-1:0]]),
        .o_frame (w_frame)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_in_word.operation == OP_TICK)) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_state = w_upd_ok ? ST_COMMAND : ST_IDLE;
            end
            ST_COMMAND: begin
                n_state = w_send ? ST_WALK : ST_IDLE;
            end
            ST_WALK: begin
                if (w_walk_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_value    = r_value;
        n_tlm      = r_tlm;
        n_q_head   = r_q_head;
        n_q_count  = r_q_count;
        n_act      = r_act;
        n_rep      = r_rep;
        n_post     = r_post;
        n_last_cmd = r_last_cmd;
        n_last_upd = r_last_upd;
        n_mi       = r_mi;
        n_out      = r_out;
        n_out_valid = i_out_stall ? r_out_valid : 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_in_word.operation)
                        OP_WRITE: begin
                            if (r_enabled && (w_idx < CNT_W'(MOTORS))) begin
                                n_value[w_idx[MIDX_W-1:0]] =
                                    (i_in_word.throttle > THROTTLE_MAX)
                                    ? 11'(THROTTLE_MAX) : i_in_word.throttle[10:0];
                            end
                        end
                        OP_TELEM: begin
                            if ((w_idx < w_active) && is_cfg(w_idx, r_cfg_mask)) begin
                                n_tlm[w_idx[MIDX_W-1:0]] = 1'b1;
                            end
                        end
                        OP_PUSH: begin
                            if (w_push) begin
                                n_q_count = r_q_count + 1'b1;
                            end
                        end
                        OP_TICK: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_UPDATE: begin
                if (w_upd_ok) begin
                    n_last_upd = r_now;
                end
            end
            ST_COMMAND: begin
                n_mi = '0;
                if (w_pop) begin
                    n_act     = w_head_cmd;
                    n_q_head  = (r_q_head == QIDX_W'(QUEUE_DEPTH - 1))
                              ? '0 : r_q_head + 1'b1;
                    n_q_count = r_q_count - 1'b1;
                    n_post    = 1'b1;
                end else if (!w_override) begin
                    n_post = r_post && w_lt_gap;
                end
                if (w_override) begin
                    for (int m = 0; m < MOTORS; m++) begin
                        if (CNT_W'(m) < w_active) begin
                            n_value[m] = {5'd0, (w_pop ? w_head_cmd : r_act)};
                            n_tlm[m]   = 1'b1;
                        end
                    end
                    if (w_ge_rep) begin
                        n_rep      = w_rep_base - 1'b1;
                        n_last_cmd = r_now;
                    end else begin
                        n_rep = w_rep_base;
                    end
                end
            end
            ST_WALK: begin
                if (!w_walk_done && (!w_walk_cfg || w_out_free)) begin
                    n_mi = r_mi + 1'b1;
                end
                if (w_load) begin
                    n_out_valid       = 1'b1;
                    n_out.out_motor   = r_mi[2:0];
                    n_out.frame       = w_frame;
                    n_out.last        = !w_rest;
                    n_tlm[r_mi[MIDX_W-1:0]] = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_motor_count <= 4'd4;
            r_cfg_mask    <= 8'd0;
            r_interval    <= 16'd0;
            r_enabled     <= 1'b1;
            r_q_head      <= '0;
            r_q_count     <= '0;
            r_act         <= 6'd0;
            r_rep         <= 4'd0;
            r_post        <= 1'b0;
            r_last_cmd    <= 32'd0;
            r_last_upd    <= 32'd0;
            r_mi          <= '0;
            r_out_valid   <= 1'b0;
            for (int m = 0; m < MOTORS; m++) begin
                r_value[m] <= 11'd0;
                r_tlm[m]   <= 1'b0;
            end
        end else begin
            r_state     <= n_state;
            r_q_head    <= n_q_head;
            r_q_count   <= n_q_count;
            r_act       <= n_act;
            r_rep       <= n_rep;
            r_post      <= n_post;
            r_last_cmd  <= n_last_cmd;
            r_last_upd  <= n_last_upd;
            r_mi        <= n_mi;
            r_out_valid <= n_out_valid;
            r_value     <= n_value;
            r_tlm       <= n_tlm;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_MOTOR_COUNT:     r_motor_count <= i_cfg_data[3:0];
                    CFG_CONFIGURED_MASK: r_cfg_mask    <= i_cfg_data[7:0];
                    CFG_UPDATE_INTERVAL: r_interval    <= i_cfg_data;
                    CFG_MOTORS_ENABLED:  r_enabled     <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_accept) begin
            r_now <= i_in_word.now_us;
        end
        if (w_push) begin
            r_cmd_store[w_wr_addr] <= i_in_word.command_code;
        end
    end

    a_out_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_WALK))
        else $error("frame word appeared outside the motor walk");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("command queue count above depth");

    a_repeat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rep <= SPIN_REPEATS)
        else $error("repeat counter above spin repeats");

    a_no_send_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMAND && !w_send) |=> (r_state == ST_IDLE))
        else $error("held tick did not return to idle");

    a_stall_holds_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && r_out_valid && i_out_stall && !w_walk_done && w_walk_cfg)
        |=> $stable(r_mi))
        else $error("walk advanced past a configured motor under stall");

endmodule

// File: sim/dshot_motor_frame_scheduler_test.sv
`timescale 1ns / 100ps

module dshot_motor_frame_scheduler_test;
    import dmfs_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 3 + MOTORS + 8;
    localparam int IDLE_PCT      = 29;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_word    i_in_word;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_word   o_out_word;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    dshot_motor_frame_scheduler dut (.*);

    always #4 i_clk = ~i_clk;

    // scheduler state as seen from the ports
    logic [3:0]        mdl_count;
    logic [7:0]        mdl_mask;
    logic [15:0]       mdl_interval;
    logic              mdl_enabled;
    logic [10:0]       throttle_of [MOTORS];
    logic              telem_req [MOTORS];
    logic [5:0]        cmd_fifo [QUEUE_DEPTH];
    logic [QIDX_W-1:0] fifo_head;
    logic [3:0]        fifo_count;
    logic [5:0]        active_cmd;
    logic [3:0]        repeats_left;
    logic              post_delay;
    logic [31:0]       last_cmd_us;
    logic [31:0]       last_update_us;
    t_out_word         frames_due [$];

    logic        calm = 1'b0;
    logic [31:0] clock_us = '0;
    int          mismatches = 0;
    int          words_in = 0;
    int          ticks_in = 0;
    int          frames_checked = 0;
    int          cycles = 0;

    function automatic int live_motors();
        return (mdl_count > MOTORS) ? MOTORS : int'(mdl_count);
    endfunction

    function automatic logic [15:0] dshot_frame(input logic [10:0] value, input logic tlm);
        logic [11:0] p;
        p = {value, tlm};
        return {p, p[3:0] ^ p[7:4] ^ p[11:8]};
    endfunction

    // returns one when frames go out on this tick
    function automatic logic command_step(input logic [31:0] now);
        logic [31:0] since;
        int          m;
        since = now - last_cmd_us;
        if (repeats_left == 0) begin
            if (fifo_count != 0 && since > CMD_INTERVAL_US) begin
                active_cmd   = cmd_fifo[fifo_head];
                fifo_head    = QIDX_W'((int'(fifo_head) + 1) % QUEUE_DEPTH);
                fifo_count   = fifo_count - 1'b1;
                repeats_left = (active_cmd == CMD_SPIN_NORMAL ||
                                active_cmd == CMD_SPIN_REVERSED) ? SPIN_REPEATS : 4'd1;
                post_delay   = 1'b1;
            end else begin
                if (post_delay) begin
                    if (since < CMD_INTERVAL_US) return 1'b0;
                    post_delay = 1'b0;
                end
                return 1'b1;
            end
        end
        for (m = 0; m < live_motors(); m++) begin
            telem_req[m]   = 1'b1;
            throttle_of[m] = 11'(active_cmd);
        end
        if (since >= CMD_REPEAT_US) begin
            repeats_left = repeats_left - 1'b1;
            last_cmd_us  = now;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic predict_frames(input t_in_word w);
        logic [31:0] gap;
        t_out_word   f;
        int          m;
        int          lastpos;
        case (w.operation)
            OP_WRITE: begin
                if (mdl_enabled && w.motor_index < MOTORS)
                    throttle_of[w.motor_index[2:0]] = (w.throttle > THROTTLE_MAX) ?
                        11'(THROTTLE_MAX) : w.throttle[10:0];
            end
            OP_TELEM: begin
                if (w.motor_index < live_motors() && mdl_mask[w.motor_index[2:0]])
                    telem_req[w.motor_index[2:0]] = 1'b1;
            end
            OP_PUSH: begin
                if (fifo_count < QUEUE_DEPTH) begin
                    cmd_fifo[(int'(fifo_head) + int'(fifo_count)) % QUEUE_DEPTH] = w.command_code;
                    fifo_count = fifo_count + 1'b1;
                end
            end
            OP_TICK: begin
                gap = w.now_us - last_update_us;
                if (mdl_interval == 0 || gap <= 32'(mdl_interval)) return;
                last_update_us = w.now_us;
                if (!command_step(w.now_us)) return;
                lastpos = -1;
                for (m = 0; m < live_motors(); m++) begin
                    if (mdl_mask[m]) begin
                        f.out_motor = m[2:0];
                        f.frame     = dshot_frame(throttle_of[m], telem_req[m]);
                        f.last      = 1'b0;
                        telem_req[m] = 1'b0;
                        frames_due.push_back(f);
                        lastpos = frames_due.size() - 1;
                    end
                end
                if (lastpos >= 0) frames_due[lastpos].last = 1'b1;
            end
        endcase
    endtask

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_frame(input t_out_word got);
        t_out_word want;
        frames_checked++;
        if (frames_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected word motor %0d frame %h last %b",
                                    got.out_motor, got.frame, got.last));
            return;
        end
        want = frames_due.pop_front();
        if (got.out_motor != want.out_motor)
            flag_mismatch($sformatf("out_motor expected %0d got %0d",
                                    want.out_motor, got.out_motor));
        if (got.frame != want.frame)
            flag_mismatch($sformatf("frame for motor %0d expected %h got %h",
                                    want.out_motor, want.frame, got.frame));
        if (got.last != want.last)
            flag_mismatch($sformatf("last for motor %0d expected %b got %b",
                                    want.out_motor, want.last, got.last));
    endtask

    task automatic apply_config(input logic [1:0] idx, input logic [15:0] data);
        case (idx)
            CFG_MOTOR_COUNT:     mdl_count    = data[3:0];
            CFG_CONFIGURED_MASK: mdl_mask     = data[7:0];
            CFG_UPDATE_INTERVAL: mdl_interval = data;
            CFG_MOTORS_ENABLED:  mdl_enabled  = data[0];
        endcase
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) apply_config(i_cfg_index, i_cfg_data);
            if (o_out_valid && !i_out_stall) check_frame(o_out_word);
            if (i_in_valid && !o_in_stall) begin
                words_in++;
                if (i_in_word.operation == OP_TICK) ticks_in++;
                predict_frames(i_in_word);
            end
        end
    end

    always @(posedge i_clk) i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d frames outstanding",
                     cycles, frames_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_word(input t_in_word w);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    function automatic t_in_word rand_word(input t_op op);
        t_in_word w;
        w.operation    = op;
        w.motor_index  = 4'($urandom);
        w.throttle     = 16'($urandom);
        w.command_code = 6'($urandom_range(47));
        w.now_us       = $urandom;
        return w;
    endfunction

    task automatic drive_write(input logic [3:0] idx, input logic [15:0] thr);
        t_in_word w;
        w = rand_word(OP_WRITE);
        w.motor_index = idx;
        w.throttle    = thr;
        send_word(w);
    endtask

    task automatic drive_telem(input logic [3:0] idx);
        t_in_word w;
        w = rand_word(OP_TELEM);
        w.motor_index = idx;
        send_word(w);
    endtask

    task automatic drive_push(input logic [5:0] code);
        t_in_word w;
        w = rand_word(OP_PUSH);
        w.command_code = code;
        send_word(w);
    endtask

    task automatic drive_tick(input logic [31:0] step_us);
        t_in_word w;
        w = rand_word(OP_TICK);
        clock_us = clock_us + step_us;
        w.now_us = clock_us;
        send_word(w);
    endtask

    // hold the sender until every frame is back and the walk has finished
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [3:0] count, input logic [7:0] mask,
                             input logic [15:0] interval, input logic enabled);
        settle();
        cfg_write(CFG_MOTOR_COUNT, 16'(count));
        cfg_write(CFG_CONFIGURED_MASK, 16'(mask));
        cfg_write(CFG_UPDATE_INTERVAL, interval);
        cfg_write(CFG_MOTORS_ENABLED, 16'(enabled));
    endtask

    task automatic test_idle_without_interval();
        configure(4'd4, 8'hff, 16'd0, 1'b1);
        drive_write(4'd0, 16'd1234);
        drive_tick(32'd5000);
        drive_tick(32'd70000);
    endtask

    task automatic test_throttle_writes();
        configure(4'd8, 8'hff, 16'd1, 1'b1);
        drive_write(4'd0, 16'd0);
        drive_write(4'd7, 16'hffff);
        drive_write(4'd3, 16'd2048);
        drive_write(4'd5, 16'd2047);
        drive_write(4'd8, 16'd100);
        drive_write(4'd15, 16'd200);
        drive_telem(4'd3);
        drive_telem(4'd12);
        drive_tick(32'd10);
        // writes are dropped while motors are disabled
        configure(4'd8, 8'hff, 16'd1, 1'b0);
        drive_write(4'd1, 16'd500);
        drive_tick(32'd2);
    endtask

    task automatic test_rate_limit_and_mask();
        configure(4'd15, 8'ha5, 16'd65535, 1'b1);
        drive_telem(4'd2);
        drive_telem(4'd5);
        drive_tick(32'd65535);
        drive_tick(32'd1);
        configure(4'd0, 8'h00, 16'd1, 1'b1);
        drive_telem(4'd0);
        drive_tick(32'd5);
    endtask

    task automatic test_command_queue();
        configure(4'd4, 8'h0f, 16'd200, 1'b1);
        drive_push(CMD_SPIN_NORMAL);
        drive_push(6'd47);
        drive_push(CMD_SPIN_REVERSED);
        drive_push(6'd0);
        drive_push(6'd5);
        drive_push(6'd33);
        drive_push(6'd1);
        drive_push(6'd42);
        drive_push(6'd9);
    endtask

    task automatic test_random_traffic(input int words, input int max_step);
        int r;
        repeat (words) begin
            r = $urandom_range(99);
            if (r < 50)
                drive_tick(32'($urandom_range(max_step)));
            else if (r < 65)
                drive_write(4'($urandom), 16'($urandom_range(2047)));
            else if (r < 80)
                drive_write(4'($urandom), 16'($urandom));
            else if (r < 94)
                drive_telem(4'($urandom));
            else
                drive_push(6'($urandom_range(47)));
        end
    endtask

    task automatic test_random_settings(input int words);
        logic [15:0] interval;
        interval = 16'($urandom_range(3000, 1));
        configure(4'($urandom), 8'($urandom), interval, $urandom_range(99) < 75);
        test_random_traffic(words, 2 * int'(interval) + 2000);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_word   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        mdl_count      = 4'd4;
        mdl_mask       = 8'h00;
        mdl_interval   = 16'd0;
        mdl_enabled    = 1'b1;
        fifo_head      = '0;
        fifo_count     = '0;
        active_cmd     = '0;
        repeats_left   = '0;
        post_delay     = 1'b0;
        last_cmd_us    = '0;
        last_update_us = '0;
        for (int m = 0; m < MOTORS; m++) begin
            throttle_of[m] = '0;
            telem_req[m]   = 1'b0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_without_interval();
        test_throttle_writes();
        test_rate_limit_and_mask();
        test_command_queue();

        configure(4'd8, 8'hff, 16'd500, 1'b1);
        calm = 1'b1;
        test_random_traffic(70, 2500);
        calm = 1'b0;
        // time wraps during this stretch
        clock_us = 32'hffff_c000;
        test_random_settings(70);
        configure(4'd9, 8'h81, 16'd65535, 1'b1);
        test_random_traffic(40, 140000);
        test_random_settings(70);

        settle();
        $display("covered %0d input words, %0d of them ticks, and checked %0d frames",
                 words_in, ticks_in, frames_checked);
        $display("settings ranged over motor counts 0 to 15, masks 0x00 to 0xff, "
                 , "intervals 0 to 65535, writes enabled and disabled, time wrap");
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
